@@ hdl/pdh_pkg.sv @@
// Package with shared types and codes of the pair distance histogram.
`default_nettype none
package pdh_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ACC    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MIN_RADIUS = 3'd0;
  localparam logic [2:0] REG_INV_WIDTH  = 3'd1;
  localparam logic [2:0] REG_WEIGHT     = 3'd2;
  localparam logic [2:0] REG_TYPE_COUNT = 3'd3;
  localparam logic [2:0] REG_BIN_COUNT  = 3'd4;

  // Work kinds passed from the front to the back.
  typedef enum logic [1:0] {
    KIND_REPLY,
    KIND_CLEAR,
    KIND_ACC,
    KIND_READ
  } kind_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_ROOT,
    F_SUB,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_INIT,
    B_IDLE,
    B_ACCESS,
    B_CLEAR
  } back_state_e;

  // Configuration register set.
  typedef struct packed {
    logic [23:0] min_radius;
    logic [23:0] inv_bin_width;
    logic [24:0] bin_weight;
    logic [2:0]  type_count;
    logic [8:0]  bin_count;
  } cfg_t;

  // Work descriptor, without the store address.
  typedef struct packed {
    kind_e      kind;
    logic [1:0] status;
    logic [7:0] hit;
  } desc_t;

endpackage
`default_nettype wire

@@ hdl/pdh_in_if.sv @@
// Input item channel of the pair distance histogram.
`default_nettype none
interface pdh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  lag;
  logic [1:0]  type_first;
  logic [1:0]  type_second;
  logic        same_atom;
  logic [31:0] dist_sq;
  logic [4:0]  read_slot;
  logic [7:0]  read_bin;

  modport source (output valid, op, lag, type_first, type_second, same_atom, dist_sq,
                  read_slot, read_bin, input ready);
  modport sink (input valid, op, lag, type_first, type_second, same_atom, dist_sq,
                read_slot, read_bin, output ready);
endinterface
`default_nettype wire

@@ hdl/pdh_out_if.sv @@
// Result channel of the pair distance histogram.
`default_nettype none
interface pdh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [7:0]  hit_bin;
  logic [1:0]  status;

  modport source (output valid, read_value, hit_bin, status, input ready);
  modport sink (input valid, read_value, hit_bin, status, output ready);
endinterface
`default_nettype wire

@@ hdl/pdh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/pdh_fifo.sv @@
// Two-entry queue between the front and the back.
`default_nettype none
module pdh_fifo #(
  parameter int WIDTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);
  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) count_q <= count_q + 2'd1;
      else if (do_pop && !do_push) count_q <= count_q - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end
endmodule
`default_nettype wire

@@ hdl/pdh_front.sv @@
// Front: accepts items, checks ranges, takes the square root and finds the bin.
`default_nettype none
module pdh_front #(
  parameter int MAX_LAGS  = 8,
  parameter int MAX_TYPES = 4,
  parameter int MAX_BINS  = 256,
  parameter int AW        = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           enable_i,
  input  wire pdh_pkg::cfg_t  cfg_i,
  pdh_in_if.sink              in_i,
  output logic                push_valid_o,
  input  wire logic           push_ready_i,
  output pdh_pkg::desc_t      push_desc_o,
  output logic [AW-1:0]       push_addr_o
);
  import pdh_pkg::*;

  localparam int SLOTS_MAX = MAX_TYPES * (MAX_TYPES + 1);
  localparam int LAG_WORDS = SLOTS_MAX * MAX_BINS;

  front_state_e state_q, state_d;
  desc_t        desc_q, desc_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [49:0]  rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic [47:0]  prod_q, prod_d;

  logic         accept, lag_ok, types_ok, read_ok;
  logic [1:0]   t_lo, t_hi;
  logic [7:0]   n, half, slot;
  logic [AW-1:0] base;
  logic [49:0]  trial;
  logic [23:0]  radius;
  logic [15:0]  bin;

  assign in_i.ready   = enable_i && (state_q == F_IDLE);
  assign accept       = in_i.valid && in_i.ready;
  assign push_valid_o = (state_q == F_PUSH);
  assign push_desc_o  = desc_q;
  assign push_addr_o  = addr_q;

  // Range checks and the dense pair slot index.
  always_comb begin
    n        = 8'(cfg_i.type_count);
    half     = 8'((n * (n + 8'd1)) >> 1);
    lag_ok   = (32'(in_i.lag) < MAX_LAGS);
    types_ok = (8'(in_i.type_first) < n) && (8'(in_i.type_second) < n);
    read_ok  = (8'(in_i.read_slot) < 8'(half << 1)) &&
               (9'(in_i.read_bin) < cfg_i.bin_count);
    t_lo     = (in_i.type_first < in_i.type_second) ? in_i.type_first : in_i.type_second;
    t_hi     = (in_i.type_first < in_i.type_second) ? in_i.type_second : in_i.type_first;
    slot     = 8'((8'(t_lo) * (8'(n << 1) - 8'(t_lo) + 8'd1)) >> 1) + 8'(t_hi - t_lo);
    if (in_i.same_atom) slot = slot + half;
    base     = AW'(in_i.lag) * AW'(LAG_WORDS);
  end

  // One step of the bitwise root, and the bin from the product.
  assign trial  = res_q + bit_q;
  assign radius = res_q[23:0];
  assign bin    = prod_q[47:32];

  // Next state and datapath.
  always_comb begin
    state_d = state_q;
    desc_d  = desc_q;
    addr_d  = addr_q;
    rem_d   = rem_q;
    res_d   = res_q;
    bit_d   = bit_q;
    prod_d  = prod_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          desc_d  = '{kind: KIND_REPLY, status: ST_RANGE, hit: 8'd0};
          state_d = F_PUSH;
          case (in_i.op)
            OP_CLEAR: begin
              if (lag_ok) begin
                desc_d.kind   = KIND_CLEAR;
                desc_d.status = ST_DONE;
                addr_d        = base;
              end
            end
            OP_ACC: begin
              if (lag_ok && types_ok) begin
                addr_d  = base + AW'(slot) * AW'(MAX_BINS);
                rem_d   = 50'({in_i.dist_sq, 16'd0});
                res_d   = '0;
                bit_d   = 50'(1) << 48;
                state_d = F_ROOT;
              end
            end
            OP_READ: begin
              if (lag_ok && read_ok) begin
                desc_d.kind   = KIND_READ;
                desc_d.status = ST_DONE;
                addr_d        = base + AW'(in_i.read_slot) * AW'(MAX_BINS) +
                                AW'(in_i.read_bin);
              end
            end
            default: ;
          endcase
        end
      end
      F_ROOT: begin
        if (bit_q != '0) begin
          if (rem_q >= trial) begin
            rem_d = rem_q - trial;
            res_d = (res_q >> 1) + bit_q;
          end else begin
            res_d = res_q >> 1;
          end
          bit_d = bit_q >> 2;
        end else begin
          state_d = F_SUB;
        end
      end
      F_SUB: begin
        if (radius < cfg_i.min_radius) begin
          desc_d.status = ST_DROP;
          state_d       = F_PUSH;
        end else begin
          prod_d  = 48'(radius - cfg_i.min_radius) * 48'(cfg_i.inv_bin_width);
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        if (bin >= 16'(cfg_i.bin_count)) begin
          desc_d.status = ST_DROP;
        end else begin
          desc_d.kind   = KIND_ACC;
          desc_d.status = ST_DONE;
          desc_d.hit    = bin[7:0];
          addr_d        = addr_q + AW'(bin);
        end
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    addr_q <= addr_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    prod_q <= prod_d;
  end
endmodule
`default_nettype wire

@@ hdl/pdh_back.sv @@
// Back: clears the store, runs read-modify-write and reads, holds the result.
`default_nettype none
module pdh_back #(
  parameter int MAX_LAGS  = 8,
  parameter int MAX_TYPES = 4,
  parameter int MAX_BINS  = 256,
  parameter int AW        = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [24:0]    bin_weight_i,
  output logic                ready_o,
  input  wire logic           pop_valid_i,
  output logic                pop_ready_o,
  input  wire pdh_pkg::desc_t pop_desc_i,
  input  wire logic [AW-1:0]  pop_addr_i,
  pdh_out_if.source           out_o
);
  import pdh_pkg::*;

  localparam int SLOTS_MAX   = MAX_TYPES * (MAX_TYPES + 1);
  localparam int LAG_WORDS   = SLOTS_MAX * MAX_BINS;
  localparam int STORE_WORDS = MAX_LAGS * LAG_WORDS;

  back_state_e   state_q, state_d;
  desc_t         desc_q, desc_d;
  logic [AW-1:0] addr_q, addr_d, cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_value_q, out_value_d;
  logic [7:0]    out_hit_q, out_hit_d;
  logic [1:0]    out_status_q, out_status_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic [32:0]   sum;
  logic          slot_free;

  pdh_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ready_o        = (state_q != B_INIT);
  assign slot_free      = !out_valid_q || out_o.ready;
  assign sum            = 33'(rdata) + 33'(bin_weight_i);
  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_value_q;
  assign out_o.hit_bin    = out_hit_q;
  assign out_o.status     = out_status_q;

  // Sequencer over the store.
  always_comb begin
    state_d      = state_q;
    desc_d       = desc_q;
    addr_d       = addr_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_hit_d    = out_hit_q;
    out_status_d = out_status_q;
    pop_ready_o  = 1'b0;
    we           = 1'b0;
    waddr        = addr_q;
    wdata        = '0;
    raddr        = pop_addr_i;
    unique case (state_q)
      B_INIT: begin
        we    = 1'b1;
        waddr = cnt_q;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(STORE_WORDS - 1)) begin
          cnt_d   = '0;
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop_valid_i && slot_free) begin
          pop_ready_o = 1'b1;
          desc_d      = pop_desc_i;
          addr_d      = pop_addr_i;
          unique case (pop_desc_i.kind)
            KIND_REPLY: begin
              out_valid_d  = 1'b1;
              out_value_d  = '0;
              out_hit_d    = '0;
              out_status_d = pop_desc_i.status;
            end
            KIND_CLEAR: begin
              cnt_d   = '0;
              state_d = B_CLEAR;
            end
            KIND_ACC, KIND_READ: state_d = B_ACCESS;
            default: ;
          endcase
        end
      end
      B_ACCESS: begin
        out_valid_d  = 1'b1;
        out_status_d = ST_DONE;
        if (desc_q.kind == KIND_ACC) begin
          we          = 1'b1;
          wdata       = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          out_value_d = '0;
          out_hit_d   = desc_q.hit;
        end else begin
          out_value_d = rdata;
          out_hit_d   = '0;
        end
        state_d = B_IDLE;
      end
      B_CLEAR: begin
        we    = 1'b1;
        waddr = addr_q + cnt_q;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(LAG_WORDS - 1)) begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_hit_d    = '0;
          out_status_d = ST_DONE;
          state_d      = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q       <= desc_d;
    addr_q       <= addr_d;
    out_value_q  <= out_value_d;
    out_hit_q    <= out_hit_d;
    out_status_q <= out_status_d;
  end
endmodule
`default_nettype wire

@@ hdl/pair_distance_histogram_by_lag.sv @@
// Top level of the pair distance histogram: registers, front, queue and back.
// Keeps weighted pair counts per time lag, pair-type slot and radial bin in one
// RAM of MAX_LAGS*MAX_TYPES*(MAX_TYPES+1)*MAX_BINS words. After reset a clearing
// pass writes zero to every word, one per cycle, and no item is taken until it
// ends. An accumulate item runs through the bit-serial square root in the front
// (25 steps and a final check), range check, multiply and hand-over, then a
// read-modify-write in the back; the front takes the next item only once it has
// handed this one over. A clear writes one word a cycle through the RAM write
// port, covering the MAX_TYPES*(MAX_TYPES+1)*MAX_BINS words of one lag, 5120 at
// the defaults. The front works on the next item while the back finishes one.
`default_nettype none
module pair_distance_histogram_by_lag #(
  parameter int MAX_LAGS  = 8,
  parameter int MAX_TYPES = 4,
  parameter int MAX_BINS  = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pdh_in_if.sink           in_i,
  pdh_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pdh_pkg::*;

  localparam int SLOTS_MAX   = MAX_TYPES * (MAX_TYPES + 1);
  localparam int STORE_WORDS = MAX_LAGS * SLOTS_MAX * MAX_BINS;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int TYPES_RST   = (MAX_TYPES < 4) ? MAX_TYPES : 4;
  localparam int BINS_RST    = (MAX_BINS < 256) ? MAX_BINS : 256;
  localparam int QW          = AW + $bits(desc_t);

  cfg_t          cfg_q;
  logic          cfg_we;
  logic [2:0]    reg_idx;
  logic          back_ready;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  desc_t         push_desc, pop_desc;
  logic [AW-1:0] push_addr, pop_addr;
  logic [QW-1:0] pop_data;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_radius    <= '0;
      cfg_q.inv_bin_width <= 24'd65536;
      cfg_q.bin_weight    <= 25'd16777216;
      cfg_q.type_count    <= 3'(TYPES_RST);
      cfg_q.bin_count     <= 9'(BINS_RST);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_MIN_RADIUS: cfg_q.min_radius    <= pwdata[23:0];
        REG_INV_WIDTH:  cfg_q.inv_bin_width <= pwdata[23:0];
        REG_WEIGHT:     cfg_q.bin_weight    <= pwdata[24:0];
        REG_TYPE_COUNT: begin
          if (pwdata[2:0] == 3'd0) cfg_q.type_count <= 3'd1;
          else if (32'(pwdata[2:0]) > MAX_TYPES) cfg_q.type_count <= 3'(MAX_TYPES);
          else cfg_q.type_count <= pwdata[2:0];
        end
        REG_BIN_COUNT: begin
          if (pwdata[8:0] == 9'd0) cfg_q.bin_count <= 9'd1;
          else if (32'(pwdata[8:0]) > MAX_BINS) cfg_q.bin_count <= 9'(MAX_BINS);
          else cfg_q.bin_count <= pwdata[8:0];
        end
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_MIN_RADIUS: prdata = 32'(cfg_q.min_radius);
      REG_INV_WIDTH:  prdata = 32'(cfg_q.inv_bin_width);
      REG_WEIGHT:     prdata = 32'(cfg_q.bin_weight);
      REG_TYPE_COUNT: prdata = 32'(cfg_q.type_count);
      REG_BIN_COUNT:  prdata = 32'(cfg_q.bin_count);
      default:        prdata = '0;
    endcase
  end

  pdh_front #(
    .MAX_LAGS(MAX_LAGS), .MAX_TYPES(MAX_TYPES), .MAX_BINS(MAX_BINS), .AW(AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (back_ready),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_desc_o  (push_desc),
    .push_addr_o  (push_addr)
  );

  pdh_fifo #(.WIDTH(QW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_addr, push_desc}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_addr = pop_data[QW-1:$bits(desc_t)];
  assign pop_desc = desc_t'(pop_data[$bits(desc_t)-1:0]);

  pdh_back #(
    .MAX_LAGS(MAX_LAGS), .MAX_TYPES(MAX_TYPES), .MAX_BINS(MAX_BINS), .AW(AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bin_weight_i (cfg_q.bin_weight),
    .ready_o      (back_ready),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_desc_i   (pop_desc),
    .pop_addr_i   (pop_addr),
    .out_o        (out_o)
  );
endmodule
`default_nettype wire
